// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CHK_ON_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pea_pkg.sv =====
package pea_pkg;

  localparam int MAX_SCREEN = 4096;
  localparam int LIM_W      = $clog2(MAX_SCREEN + 1);   // effective screen limit
  localparam int POS_W      = $clog2(MAX_SCREEN);       // pixel coordinate
  localparam int CFG_DIM_W  = 13;
  localparam int RAW_W      = 32;
  localparam int QUO_W      = POS_W;
  localparam int PROD_W     = RAW_W + POS_W;
  localparam int STEP_CNT_W = $clog2(QUO_W);
  localparam int WHEEL_W    = 6;
  localparam int WHEEL_LIM  = 20;

  localparam int TYPE_W     = 5;
  localparam int CODE_W     = 10;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;

  // event types
  localparam logic [TYPE_W-1:0] EV_SYN = 5'd0;
  localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
  localparam logic [TYPE_W-1:0] EV_REL = 5'd2;
  localparam logic [TYPE_W-1:0] EV_ABS = 5'd3;

  // event codes
  localparam logic [CODE_W-1:0] SYN_FRAME    = 10'h000;
  localparam logic [CODE_W-1:0] SYN_LOST     = 10'h003;
  localparam logic [CODE_W-1:0] ABS_X        = 10'h000;
  localparam logic [CODE_W-1:0] ABS_Y        = 10'h001;
  localparam logic [CODE_W-1:0] ABS_MT_X     = 10'h035;
  localparam logic [CODE_W-1:0] ABS_MT_Y     = 10'h036;
  localparam logic [CODE_W-1:0] ABS_MT_TRACK = 10'h039;
  localparam logic [CODE_W-1:0] REL_X        = 10'h000;
  localparam logic [CODE_W-1:0] REL_Y        = 10'h001;
  localparam logic [CODE_W-1:0] REL_SCROLL   = 10'h008;
  localparam logic [CODE_W-1:0] KEY_LEFT_BTN  = 10'h110;
  localparam logic [CODE_W-1:0] KEY_TOUCH_BTN = 10'h14a;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_W, REG_SCREEN_H, REG_ABS_MODE,
    REG_X_MIN, REG_X_MAX, REG_Y_MIN, REG_Y_MAX
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BC_NONE     = 2'd0,
    BC_RELEASED = 2'd1,
    BC_PRESSED  = 2'd2
  } btn_change_t;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_CHECK, S_WAIT} pea_state_t;

  typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_STEP} div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // limit register saturated to MAX_SCREEN, zero taken as one
  function automatic logic [LIM_W-1:0] eff_limit(input logic [CFG_DIM_W-1:0] r);
    logic [LIM_W-1:0] l;
    if (r == '0)
      l = LIM_W'(1);
    else if (int'(r) > MAX_SCREEN)
      l = LIM_W'(MAX_SCREEN);
    else
      l = LIM_W'(r);
    return l;
  endfunction

endpackage

// ===== hdl/pea_div.sv =====
module pea_div import pea_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [RAW_W-1:0]    diff_i,     // numerator before scaling, < divisor_i
  input  logic [LIM_W-1:0]    scale_i,
  input  logic [RAW_W-1:0]    divisor_i,
  output logic [QUO_W-1:0]    quo_o,
  output div_stat_t           stat_o
);

  div_state_t              st_r, st_nxt;
  logic [RAW_W-1:0]        diff_r, diff_nxt;
  logic [LIM_W-1:0]        scale_r, scale_nxt;
  logic [RAW_W-1:0]        dvs_r, dvs_nxt;
  logic [RAW_W-1:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]        low_r, low_nxt;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic [STEP_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;

  logic [PROD_W-1:0]       prod;
  logic [RAW_W:0]          rem_sh;
  logic                    ge;

  assign prod   = PROD_W'(diff_r) * PROD_W'(scale_r);
  assign rem_sh = {rem_r, low_r[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    diff_r  <= diff_nxt;
    scale_r <= scale_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    low_r   <= low_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    done_nxt  = 1'b0;
    diff_nxt  = diff_r;
    scale_nxt = scale_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    case (st_r)
      DV_IDLE: begin
        if (start) begin
          diff_nxt  = diff_i;
          scale_nxt = scale_i;
          dvs_nxt   = divisor_i;
          st_nxt    = DV_MUL;
        end
      end
      DV_MUL: begin
        // quotient fits QUO_W bits, so the top part is already below the divisor
        rem_nxt = prod[PROD_W-1:QUO_W];
        low_nxt = prod[QUO_W-1:0];
        quo_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = DV_STEP;
      end
      DV_STEP: begin
        rem_nxt = ge ? RAW_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[RAW_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        low_nxt = {low_r[QUO_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(QUO_W - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = DV_IDLE;
        end
      end
      default: st_nxt = DV_IDLE;
    endcase
  end

  assign quo_o       = quo_r;
  assign stat_o.busy = (st_r != DV_IDLE);
  assign stat_o.done = done_r;

endmodule

// ===== hdl/pointer_event_accumulator.sv =====
// Sync, key, relative and ignored items pass through the execute state back to ready;
// a report's frame is registered onto out_*, and it waits while the output is full.
// Absolute x/y items in range go through one multiply plus a 12-step shared serial divider;
// absolute items below or above the range or on a degenerate range resolve in S_CHECK.
// Items are not overlapped: input ready stays low until the current item is finished.
// Reset: synchronous, active low; clears the control state, loads register defaults, no clear pass.
`include "assert_macros.svh"

module pointer_event_accumulator import pea_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // event_code[9:0], event_value[41:10], zero pad
  input  logic [TYPE_W-1:0]     in_tuser,   // event_type[4:0]
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pos_x[11:0], pos_y[23:12], button_change[25:24],
                                            // moved[26], wheel_sum[32:27],
                                            // frame_changed[33], zero pad
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [RAW_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [CFG_DIM_W-1:0]    scr_w_r, scr_h_r;
  logic                    abs_mode_r;
  logic signed [RAW_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r;

  pea_state_t              st_r, st_nxt;
  logic [TYPE_W-1:0]       type_r, type_nxt;
  logic [CODE_W-1:0]       code_r, code_nxt;
  logic signed [RAW_W-1:0] value_r, value_nxt;

  logic [POS_W-1:0]        cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic                    started_r, started_nxt;
  logic                    motion_r, motion_nxt;
  logic signed [WHEEL_W-1:0] wheel_r, wheel_nxt;
  logic                    btn_now_r, btn_now_nxt;
  logic                    btn_pend_r, btn_pend_nxt;
  logic                    drop_r, drop_nxt;

  logic signed [RAW_W:0]   diff_r, diff_nxt, span_r, span_nxt;
  logic                    axis_y_r, axis_y_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]        o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  btn_change_t             o_bc_r, o_bc_nxt;
  logic                    o_moved_r, o_moved_nxt;
  logic signed [WHEEL_W-1:0] o_wheel_r, o_wheel_nxt;
  logic                    o_chg_r, o_chg_nxt;

  // combinational helpers
  logic [LIM_W-1:0]        wl, hl, abs_lim, rel_lim;
  logic [POS_W-1:0]        rel_cur;
  logic signed [RAW_W+1:0] rel_sum;
  logic                    code_is_y;
  logic signed [RAW_W-1:0] abs_lo, abs_hi;
  logic signed [WHEEL_W-1:0] wstep;
  logic signed [WHEEL_W:0] wsum;
  logic                    out_free;
  logic                    bchg;

  logic                    div_start;
  logic [QUO_W-1:0]        div_quo;
  div_stat_t               div_st;

  assign wl        = eff_limit(scr_w_r);
  assign hl        = eff_limit(scr_h_r);
  assign abs_lim   = axis_y_r ? hl : wl;
  assign code_is_y = (code_r == ABS_Y) || (code_r == ABS_MT_Y);
  assign abs_lo    = code_is_y ? y_min_r : x_min_r;
  assign abs_hi    = code_is_y ? y_max_r : x_max_r;
  assign rel_cur   = (code_r == REL_X) ? cur_x_r : cur_y_r;
  assign rel_lim   = (code_r == REL_X) ? wl : hl;
  assign rel_sum   = $signed({{(RAW_W+2-POS_W){1'b0}}, rel_cur}) + (RAW_W+2)'(value_r);
  assign out_free  = !out_valid_r || out_tready;
  assign bchg      = btn_pend_r != btn_now_r;

  always_comb begin
    if (value_r > WHEEL_LIM)
      wstep = WHEEL_W'(WHEEL_LIM);
    else if (value_r < -WHEEL_LIM)
      wstep = WHEEL_W'(-WHEEL_LIM);
    else
      wstep = value_r[WHEEL_W-1:0];
  end

  assign wsum = (WHEEL_W+1)'(wstep) + (WHEEL_W+1)'(wheel_r);

  pea_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .diff_i    (diff_r[RAW_W-1:0]),
    .scale_i   (abs_lim),
    .divisor_i (span_r[RAW_W-1:0]),
    .quo_o     (div_quo),
    .stat_o    (div_st)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r    <= CFG_DIM_W'(640);
      scr_h_r    <= CFG_DIM_W'(480);
      abs_mode_r <= 1'b0;
      x_min_r    <= '0;
      x_max_r    <= RAW_W'(4095);
      y_min_r    <= '0;
      y_max_r    <= RAW_W'(4095);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_W: scr_w_r    <= cfg_wdata[CFG_DIM_W-1:0];
        REG_SCREEN_H: scr_h_r    <= cfg_wdata[CFG_DIM_W-1:0];
        REG_ABS_MODE: abs_mode_r <= cfg_wdata[0];
        REG_X_MIN:    x_min_r    <= cfg_wdata;
        REG_X_MAX:    x_max_r    <= cfg_wdata;
        REG_Y_MIN:    y_min_r    <= cfg_wdata;
        REG_Y_MAX:    y_max_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      started_r   <= 1'b0;
      motion_r    <= 1'b0;
      wheel_r     <= '0;
      btn_now_r   <= 1'b0;
      btn_pend_r  <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      started_r   <= started_nxt;
      motion_r    <= motion_nxt;
      wheel_r     <= wheel_nxt;
      btn_now_r   <= btn_now_nxt;
      btn_pend_r  <= btn_pend_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r    <= type_nxt;
    code_r    <= code_nxt;
    value_r   <= value_nxt;
    diff_r    <= diff_nxt;
    span_r    <= span_nxt;
    axis_y_r  <= axis_y_nxt;
    o_x_r     <= o_x_nxt;
    o_y_r     <= o_y_nxt;
    o_bc_r    <= o_bc_nxt;
    o_moved_r <= o_moved_nxt;
    o_wheel_r <= o_wheel_nxt;
    o_chg_r   <= o_chg_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    type_nxt      = type_r;
    code_nxt      = code_r;
    value_nxt     = value_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    started_nxt   = started_r;
    motion_nxt    = motion_r;
    wheel_nxt     = wheel_r;
    btn_now_nxt   = btn_now_r;
    btn_pend_nxt  = btn_pend_r;
    drop_nxt      = drop_r;
    diff_nxt      = diff_r;
    span_nxt      = span_r;
    axis_y_nxt    = axis_y_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_x_nxt       = o_x_r;
    o_y_nxt       = o_y_r;
    o_bc_nxt      = o_bc_r;
    o_moved_nxt   = o_moved_r;
    o_wheel_nxt   = o_wheel_r;
    o_chg_nxt     = o_chg_r;
    div_start     = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          type_nxt  = in_tuser;
          code_nxt  = in_tdata[CODE_W-1:0];
          value_nxt = in_tdata[CODE_W+RAW_W-1:CODE_W];
          // first item ever centers the pointer
          if (!started_r) begin
            cur_x_nxt   = POS_W'(wl >> 1);
            cur_y_nxt   = POS_W'(hl >> 1);
            started_nxt = 1'b1;
          end
          st_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        st_nxt = S_IDLE;
        if (type_r == EV_SYN && code_r == SYN_LOST) begin
          drop_nxt     = 1'b1;
          motion_nxt   = 1'b0;
          wheel_nxt    = '0;
          btn_pend_nxt = 1'b0;
        end else if (type_r == EV_SYN && code_r == SYN_FRAME) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            o_x_nxt       = cur_x_r;
            o_y_nxt       = cur_y_r;
            o_bc_nxt      = bchg ? (btn_pend_r ? BC_PRESSED : BC_RELEASED) : BC_NONE;
            o_moved_nxt   = motion_r;
            o_wheel_nxt   = wheel_r;
            o_chg_nxt     = motion_r || (wheel_r != '0) || bchg;
            btn_now_nxt   = btn_pend_r;
            motion_nxt    = 1'b0;
            wheel_nxt     = '0;
            drop_nxt      = 1'b0;
          end else begin
            st_nxt = S_EXEC;
          end
        end else if (drop_r) begin
          // everything but sync is discarded until the next report
        end else if (type_r == EV_ABS && abs_mode_r) begin
          if (code_r == ABS_X || code_r == ABS_MT_X || code_is_y) begin
            axis_y_nxt = code_is_y;
            diff_nxt   = (RAW_W+1)'(value_r) - (RAW_W+1)'(abs_lo);
            span_nxt   = (RAW_W+1)'(abs_hi) - (RAW_W+1)'(abs_lo);
            st_nxt     = S_CHECK;
          end else if (code_r == ABS_MT_TRACK) begin
            btn_pend_nxt = !value_r[RAW_W-1];
          end
        end else if (type_r == EV_REL) begin
          if (code_r == REL_X || code_r == REL_Y) begin
            if (rel_sum < 0)
              cur_x_nxt = '0;
            else if (rel_sum >= $signed({{(RAW_W+2-LIM_W){1'b0}}, rel_lim}))
              cur_x_nxt = POS_W'(rel_lim - 1'b1);
            else
              cur_x_nxt = rel_sum[POS_W-1:0];
            if (code_r == REL_Y) begin
              cur_y_nxt = cur_x_nxt;
              cur_x_nxt = cur_x_r;
            end
            motion_nxt = 1'b1;
          end else if (code_r == REL_SCROLL) begin
            if (wsum > WHEEL_LIM)
              wheel_nxt = WHEEL_W'(WHEEL_LIM);
            else if (wsum < -WHEEL_LIM)
              wheel_nxt = WHEEL_W'(-WHEEL_LIM);
            else
              wheel_nxt = wsum[WHEEL_W-1:0];
          end
        end else if (type_r == EV_KEY &&
                     (code_r == KEY_LEFT_BTN || code_r == KEY_TOUCH_BTN)) begin
          btn_pend_nxt = (value_r != '0);
        end
      end

      S_CHECK: begin
        // edge cases resolve here; only 0 <= diff < span goes to the divider
        st_nxt = S_IDLE;
        if (span_r <= 0 || diff_r < 0 || diff_r >= span_r) begin
          if (span_r <= 0)
            cur_x_nxt = POS_W'(abs_lim >> 1);
          else if (diff_r < 0)
            cur_x_nxt = '0;
          else
            cur_x_nxt = POS_W'(abs_lim - 1'b1);
          if (axis_y_r) begin
            cur_y_nxt = cur_x_nxt;
            cur_x_nxt = cur_x_r;
          end
          motion_nxt = 1'b1;
        end else begin
          div_start = 1'b1;
          st_nxt    = S_WAIT;
        end
      end

      S_WAIT: begin
        if (div_st.done) begin
          if (axis_y_r)
            cur_y_nxt = div_quo;
          else
            cur_x_nxt = div_quo;
          motion_nxt = 1'b1;
          st_nxt     = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2*POS_W-4-WHEEL_W){1'b0}}, o_chg_r, o_wheel_r,
                       o_moved_r, o_bc_r, o_y_r, o_x_r};

  `CHK_ON_CLK(a_ready_div_idle, in_tready |-> !div_st.busy, "input ready while divider busy")
  `CHK_ON_CLK(a_div_done_wait, div_st.done |-> (st_r == S_WAIT), "divider done outside wait")
  `CHK_ON_CLK(a_wheel_range, (wheel_r <= 6'sd20) && (wheel_r >= -6'sd20), "wheel sum out of range")
  `CHK_ALWAYS(a_reset_idle, !rst_n |=> (st_r == S_IDLE) && !out_valid_r, "not idle after reset")

endmodule
